FILE: hw/rtl/wis_pkg.sv
package wis_pkg;

    localparam int MAX_ENTRIES = 256;
    localparam int WEIGHT_BITS = 16;
    localparam int RAND_BITS   = 32;

    localparam int IDX_BITS  = $clog2(MAX_ENTRIES);
    localparam int CNT_BITS  = $clog2(MAX_ENTRIES + 1);
    localparam int SUM_BITS  = WEIGHT_BITS + IDX_BITS;
    localparam int PROD_BITS = RAND_BITS + SUM_BITS;

    localparam logic [CNT_BITS-1:0] CNT_ONE = CNT_BITS'(1);

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_DRAW  = 1'b1;

    typedef logic [IDX_BITS-1:0]    idx_t;
    typedef logic [CNT_BITS-1:0]    cnt_t;
    typedef logic [WEIGHT_BITS-1:0] weight_t;
    typedef logic [SUM_BITS-1:0]    sum_t;
    typedef logic [PROD_BITS-1:0]   prod_t;

    typedef struct packed {
        logic    en;
        idx_t    addr;
        weight_t data;
    } tbl_wr_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SUM  = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_SCAN = 5'b01000,
        ST_HOLD = 5'b10000
    } state_t;

    function automatic idx_t wrap_index(input logic [7:0] i);
        logic [31:0] w;
        w = 32'(i) % MAX_ENTRIES;
        return w[IDX_BITS-1:0];
    endfunction

    function automatic weight_t fit_weight(input logic [15:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[WEIGHT_BITS-1:0];
    endfunction

    function automatic cnt_t clamp_count(input logic [8:0] v);
        logic [31:0] w;
        w = 32'(v);
        if (w == 32'd0) begin
            w = 32'd1;
        end
        if (w > 32'(MAX_ENTRIES)) begin
            w = 32'(MAX_ENTRIES);
        end
        return w[CNT_BITS-1:0];
    endfunction

    function automatic logic [7:0] out_index(input idx_t i);
        logic [31:0] w;
        w = 32'(i);
        return w[7:0];
    endfunction

endpackage

FILE: hw/rtl/weighted_index_sampler.sv
// Weighted index sampler (roulette-wheel selection).
// Input channel s_*: valid/ready requests. s_mode 0 stores s_weight at
// s_entry_index and yields no result; s_mode 1 draws an index using the
// 32-bit fraction s_random_fraction.
// Result channel m_*: one m_selected_index per draw, valid/ready.
// cfg_wr_en/cfg_wr_data write entries_in_use (n); write only while idle.
// A draw walks the weight table twice through its single read port
// (once when all weights are zero): one pass for the total, then a
// multiply, then a search pass that stops at the first entry whose
// running sum reaches the threshold, then a load of the output
// register. When all weights are zero the search pass is skipped and
// index 0 is given. A new request is accepted once the previous one
// is finished, even while its result waits on m_ready.
// A finished draw holds if the output register is still occupied.
// Reset clears the weight table (per-entry valid bits), sets n to 256,
// empties the output and returns to idle within the reset cycle.
module weighted_index_sampler (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [8:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [7:0]  s_entry_index,
    input  logic [15:0] s_weight,
    input  logic [31:0] s_random_fraction,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_selected_index
);

    wis_pkg::state_t  state_reg, state_next;
    wis_pkg::cnt_t    n_reg;
    wis_pkg::cnt_t    issue_reg, issue_next;
    logic             pend_reg, pend_next;
    wis_pkg::idx_t    pidx_reg, pidx_next;
    wis_pkg::sum_t    acc_reg, acc_next;
    logic [31:0]      rand_reg, rand_next;
    wis_pkg::prod_t   prod_reg, prod_next;
    wis_pkg::idx_t    pick_reg, pick_next;
    logic             m_valid_reg, m_valid_next;
    logic [7:0]       m_index_reg, m_index_next;

    wis_pkg::tbl_wr_t tbl_wr;
    wis_pkg::weight_t rd_weight;
    wis_pkg::sum_t    run;
    wis_pkg::prod_t   run_scaled;
    wis_pkg::cnt_t    last_cnt;
    logic             accept;

    wis_table u_table (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr        (tbl_wr),
        .rd_addr   (issue_reg[wis_pkg::IDX_BITS-1:0]),
        .rd_weight (rd_weight)
    );

    assign s_ready          = (state_reg == wis_pkg::ST_IDLE);
    assign accept           = s_valid && s_ready;
    assign m_valid          = m_valid_reg;
    assign m_selected_index = m_index_reg;

    assign tbl_wr.en   = accept && (s_mode == wis_pkg::MODE_WRITE);
    assign tbl_wr.addr = wis_pkg::wrap_index(s_entry_index);
    assign tbl_wr.data = wis_pkg::fit_weight(s_weight);

    assign run        = acc_reg + wis_pkg::sum_t'(rd_weight);
    assign run_scaled = {run, 32'd0};
    assign last_cnt   = n_reg - wis_pkg::CNT_ONE;

    always_comb begin
        state_next   = state_reg;
        issue_next   = issue_reg;
        pend_next    = 1'b0;
        pidx_next    = issue_reg[wis_pkg::IDX_BITS-1:0];
        acc_next     = acc_reg;
        rand_next    = rand_reg;
        prod_next    = prod_reg;
        pick_next    = pick_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_index_next = m_index_reg;

        case (state_reg)
            wis_pkg::ST_IDLE: begin
                if (accept && (s_mode == wis_pkg::MODE_DRAW)) begin
                    rand_next  = s_random_fraction;
                    acc_next   = '0;
                    issue_next = '0;
                    state_next = wis_pkg::ST_SUM;
                end
            end
            wis_pkg::ST_SUM: begin
                if (issue_reg < n_reg) begin
                    issue_next = issue_reg + wis_pkg::CNT_ONE;
                    pend_next  = 1'b1;
                end
                if (pend_reg) begin
                    acc_next = run;
                end
                if (issue_reg == n_reg && !pend_reg) begin
                    state_next = wis_pkg::ST_MUL;
                end
            end
            wis_pkg::ST_MUL: begin
                prod_next  = wis_pkg::prod_t'(rand_reg) * wis_pkg::prod_t'(acc_reg);
                acc_next   = '0;
                issue_next = '0;
                if (acc_reg == '0) begin
                    pick_next  = '0;
                    state_next = wis_pkg::ST_HOLD;
                end else begin
                    state_next = wis_pkg::ST_SCAN;
                end
            end
            wis_pkg::ST_SCAN: begin
                if (issue_reg < n_reg) begin
                    issue_next = issue_reg + wis_pkg::CNT_ONE;
                    pend_next  = 1'b1;
                end
                if (pend_reg) begin
                    acc_next = run;
                end
                if (pend_reg && run_scaled >= prod_reg) begin
                    pick_next  = pidx_reg;
                    pend_next  = 1'b0;
                    state_next = wis_pkg::ST_HOLD;
                end else if (issue_reg == n_reg && !pend_reg) begin
                    // guard: threshold never reached
                    pick_next  = last_cnt[wis_pkg::IDX_BITS-1:0];
                    state_next = wis_pkg::ST_HOLD;
                end
            end
            wis_pkg::ST_HOLD: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_index_next = wis_pkg::out_index(pick_reg);
                    state_next   = wis_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = wis_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= wis_pkg::ST_IDLE;
            n_reg       <= wis_pkg::clamp_count(9'd256);
            issue_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            issue_reg   <= issue_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                n_reg <= wis_pkg::clamp_count(cfg_wr_data);
            end
        end
    end

    always_ff @(posedge aclk) begin
        pidx_reg    <= pidx_next;
        acc_reg     <= acc_next;
        rand_reg    <= rand_next;
        prod_reg    <= prod_next;
        pick_reg    <= pick_next;
        m_index_reg <= m_index_next;
    end

endmodule

FILE: hw/rtl/wis_table.sv
module wis_table (
    input  logic              aclk,
    input  logic              aresetn,
    input  wis_pkg::tbl_wr_t  wr,
    input  wis_pkg::idx_t     rd_addr,
    output wis_pkg::weight_t  rd_weight
);

    wis_pkg::weight_t mem [wis_pkg::MAX_ENTRIES];
    logic [wis_pkg::MAX_ENTRIES-1:0] valid_reg;
    wis_pkg::weight_t rd_data_reg;
    logic             rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // unwritten entries read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr.en) begin
                valid_reg[wr.addr] <= 1'b1;
            end
            rd_vld_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_weight = rd_vld_reg ? rd_data_reg : '0;

endmodule

FILE: hw/rtl/wis_checker.sv
module wis_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       s_mode,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_selected_index
);

    // a draw keeps the block busy after it is accepted
    a_draw_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_mode == wis_pkg::MODE_DRAW) |=> !s_ready)
        else $error("request accepted during a draw");

    // a weight write produces no result
    a_write_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_mode == wis_pkg::MODE_WRITE) && !m_valid |=> !m_valid)
        else $error("result after a weight write");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_selected_index))
        else $error("result changed while stalled");

endmodule

bind weighted_index_sampler wis_checker u_wis_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .s_mode           (s_mode),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_selected_index (m_selected_index)
);
